### src/tms_pkg.sv
// Package: sizes, codes and shared types of the Turing machine stepper.
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  localparam int TAPE_DEPTH  = 256;
  localparam int TRANS_DEPTH = 64;
  localparam int STATE_COUNT = 16;

  localparam int STATE_W = $clog2(STATE_COUNT);
  localparam int SYM_W   = 8;
  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int ENTRY_W = 6;
  localparam int MOVE_W  = 2;
  localparam int CMD_W   = 2;
  localparam int LEFT_W  = $clog2(TRANS_DEPTH + 1);
  localparam int CFG_W   = 7;

  localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TAPE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STEP       = 2'd3;

  localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd2;

  localparam logic [TAPE_AW-1:0] HEAD_LAST = TAPE_AW'(TAPE_DEPTH - 1);

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   read_symbol;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   write_symbol;
    logic [MOVE_W-1:0]  move;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
    logic [SYM_W-1:0]   symbol;
    logic [LEFT_W-1:0]  left;
    logic               hit;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   write_symbol;
    logic [MOVE_W-1:0]  move;
  } tok_t;

endpackage

`default_nettype wire

### src/tms_if.sv
// Interfaces: request, response and configuration channels of the stepper.
`timescale 1ns / 1ps
`default_nettype none

interface tms_req_if;
  import tms_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ENTRY_W-1:0] entry_index;
  logic [STATE_W-1:0] from_state;
  logic [SYM_W-1:0]   read_symbol;
  logic [STATE_W-1:0] to_state;
  logic [SYM_W-1:0]   write_symbol;
  logic [MOVE_W-1:0]  move;
  logic [TAPE_AW-1:0] tape_address;
  logic [SYM_W-1:0]   tape_symbol;

  modport source (
    output valid, command, entry_index, from_state, read_symbol, to_state,
           write_symbol, move, tape_address, tape_symbol,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, from_state, read_symbol, to_state,
           write_symbol, move, tape_address, tape_symbol,
    output ready
  );
endinterface

interface tms_rsp_if;
  import tms_pkg::*;
  logic               valid;
  logic               ready;
  logic               halted;
  logic               head_fault;
  logic [STATE_W-1:0] current_state;
  logic [TAPE_AW-1:0] head_position;
  logic [SYM_W-1:0]   written_symbol;

  modport source (
    output valid, halted, head_fault, current_state, head_position, written_symbol,
    input  ready
  );
  modport sink (
    input  valid, halted, head_fault, current_state, head_position, written_symbol,
    output ready
  );
endinterface

interface tms_cfg_if;
  import tms_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink (input valid, entries_in_use, output ready);
endinterface

`default_nettype wire

### src/turing_machine_stepper.sv
// Top level: single-tape Turing machine stepper with a cell-chain entry search.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    command, entry, tape load fields
//   rsp_o    out  valid/ready    halted, head_fault, state, head, symbol
//   cfg_i    in   valid/ready    entries_in_use
//
// Load and restart requests complete in the accept cycle. A step passes through
// the accept cycle, a tape read, the crossing of the match token along the chain
// of entry cells with the capture on the last, and a write-back cycle. A halted
// machine skips the chain and goes from the tape read straight to the response.
// Reset clears the tape valid bits, so every cell reads zero until written by a load or a step.
// A finished step waits in its last cycle while the response register is full and not being taken.
`timescale 1ns / 1ps
`default_nettype none

module turing_machine_stepper
  import tms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tms_req_if.sink   req_i,
  tms_rsp_if.source rsp_o,
  tms_cfg_if.sink   cfg_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_q;
  logic [CFG_W-1:0]      limit_q;
  logic [STATE_W-1:0]    mstate_q;
  logic [TAPE_AW-1:0]    head_q;
  logic                  halt_q;
  logic [SYM_W-1:0]      under_q;
  tok_t                  fin_q;
  logic [TAPE_DEPTH-1:0] tape_vld_q;
  logic                  vld_rd_q;

  logic                  out_valid_q;
  logic                  out_halted_q;
  logic                  out_fault_q;
  logic [STATE_W-1:0]    out_state_q;
  logic [TAPE_AW-1:0]    out_head_q;
  logic [SYM_W-1:0]      out_sym_q;

  logic                  req_fire;
  logic                  done_fire;
  logic [SYM_W-1:0]      rd_data;
  logic [SYM_W-1:0]      under;
  logic                  tape_we;
  logic [TAPE_AW-1:0]    tape_waddr;
  logic [SYM_W-1:0]      tape_wdata;
  logic                  fault;
  logic [TAPE_AW-1:0]    head_nx;
  logic [LEFT_W-1:0]     left_init;
  entry_t                entry_in;
  tok_t                  chain [TRANS_DEPTH+1];

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign done_fire   = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.entries_in_use;
    end
  end

  assign left_init = (limit_q > CFG_W'(TRANS_DEPTH)) ? LEFT_W'(TRANS_DEPTH)
                                                      : LEFT_W'(limit_q);

  // tape store
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = head_q;
    tape_wdata = fin_q.write_symbol;
    if (req_fire && (req_i.command == CMD_LOAD_TAPE)) begin
      tape_we    = 1'b1;
      tape_waddr = req_i.tape_address;
      tape_wdata = req_i.tape_symbol;
    end else if (done_fire && !halt_q && fin_q.hit) begin
      tape_we = 1'b1;
    end
  end

  tms_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_vld_q <= '0;
      vld_rd_q   <= 1'b0;
    end else begin
      if (tape_we) begin
        tape_vld_q[tape_waddr] <= 1'b1;
      end
      vld_rd_q <= tape_vld_q[head_q];
    end
  end

  assign under = vld_rd_q ? rd_data : '0;

  // entry cell chain
  assign entry_in = '{
    from_state:   req_i.from_state,
    read_symbol:  req_i.read_symbol,
    to_state:     req_i.to_state,
    write_symbol: req_i.write_symbol,
    move:         req_i.move
  };

  assign chain[0] = '{
    valid:        (state_q == ST_READ) && !halt_q,
    state:        mstate_q,
    symbol:       under,
    left:         left_init,
    hit:          1'b0,
    to_state:     '0,
    write_symbol: '0,
    move:         '0
  };

  for (genvar i = 0; i < TRANS_DEPTH; i++) begin : g_cell
    tms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (req_fire && (req_i.command == CMD_LOAD_TRANS) &&
                (req_i.entry_index == ENTRY_W'(i))),
      .entry_i (entry_in),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
  end

  // head update of a fired entry
  always_comb begin
    fault   = 1'b0;
    head_nx = head_q;
    unique case (fin_q.move)
      MOVE_RIGHT: begin
        if (head_q == HEAD_LAST) begin
          fault = 1'b1;
        end else begin
          head_nx = head_q + TAPE_AW'(1);
        end
      end
      MOVE_LEFT: begin
        if (head_q == '0) begin
          fault = 1'b1;
        end else begin
          head_nx = head_q - TAPE_AW'(1);
        end
      end
      default: begin
        head_nx = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mstate_q     <= '0;
      head_q       <= '0;
      halt_q       <= 1'b0;
      under_q      <= '0;
      fin_q        <= '0;
      out_valid_q  <= 1'b0;
      out_halted_q <= 1'b0;
      out_fault_q  <= 1'b0;
      out_state_q  <= '0;
      out_head_q   <= '0;
      out_sym_q    <= '0;
    end else begin
      if (rsp_o.ready && !done_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            unique case (req_i.command)
              CMD_LOAD_TRANS, CMD_LOAD_TAPE: begin
                state_q <= ST_IDLE;
              end
              CMD_RESTART: begin
                mstate_q <= '0;
                head_q   <= '0;
                halt_q   <= 1'b0;
              end
              CMD_STEP: begin
                state_q <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          under_q <= under;
          state_q <= halt_q ? ST_DONE : ST_SCAN;
        end
        ST_SCAN: begin
          if (chain[TRANS_DEPTH].valid) begin
            fin_q   <= chain[TRANS_DEPTH];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (halt_q || !fin_q.hit) begin
              halt_q       <= 1'b1;
              out_halted_q <= 1'b1;
              out_fault_q  <= 1'b0;
              out_state_q  <= mstate_q;
              out_head_q   <= head_q;
              out_sym_q    <= under_q;
            end else begin
              mstate_q     <= fin_q.to_state;
              head_q       <= head_nx;
              halt_q       <= fault;
              out_halted_q <= fault;
              out_fault_q  <= fault;
              out_state_q  <= fin_q.to_state;
              out_head_q   <= head_nx;
              out_sym_q    <= fin_q.write_symbol;
            end
          end
        end
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.halted         = out_halted_q;
  assign rsp_o.head_fault     = out_fault_q;
  assign rsp_o.current_state  = out_state_q;
  assign rsp_o.head_position  = out_head_q;
  assign rsp_o.written_symbol = out_sym_q;

endmodule

`default_nettype wire

### src/tms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/tms_cell.sv
// Search cell: one transition entry and one stage of the match token chain.
`timescale 1ns / 1ps
`default_nettype none

module tms_cell
  import tms_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   we_i,
  input  entry_t entry_i,
  input  tok_t   tok_i,
  output tok_t   tok_o
);

  entry_t entry_q;
  tok_t   tok_d, tok_q;
  logic   match;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= entry_i;
    end
  end

  assign match = tok_i.valid && !tok_i.hit && (tok_i.left != '0) &&
                 (entry_q.from_state == tok_i.state) &&
                 (entry_q.read_symbol == tok_i.symbol);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.left != '0) begin
      tok_d.left = tok_i.left - LEFT_W'(1);
    end
    if (match) begin
      tok_d.hit          = 1'b1;
      tok_d.to_state     = entry_q.to_state;
      tok_d.write_symbol = entry_q.write_symbol;
      tok_d.move         = entry_q.move;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

### tb/tms_checker.sv
// Checker: mirrors the stepper from observed requests and compares every response.
`timescale 1ns / 1ps

module tms_checker
  import tms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tms_req_if   req_mon,
  tms_rsp_if   rsp_mon,
  tms_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic               halted;
    logic               head_fault;
    logic [STATE_W-1:0] state;
    logic [TAPE_AW-1:0] head;
    logic [SYM_W-1:0]   symbol;
  } step_result_t;

  logic [SYM_W-1:0]   tape_mirror [TAPE_DEPTH];
  entry_t             table_mirror [TRANS_DEPTH];
  logic [STATE_W-1:0] state_mirror;
  logic [TAPE_AW-1:0] head_mirror;
  logic               halt_mirror;
  logic [CFG_W-1:0]   search_limit;
  step_result_t       step_results_q [$];
  step_result_t       oldest_result;

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic step_result_t advance_machine();
    step_result_t     res;
    logic [SYM_W-1:0] under;
    int               limit;
    int               hit;
    entry_t           fired;
    logic             fault;
    under          = tape_mirror[head_mirror];
    res.halted     = 1'b1;
    res.head_fault = 1'b0;
    res.state      = state_mirror;
    res.head       = head_mirror;
    res.symbol     = under;
    if (halt_mirror) return res;
    limit = (search_limit > TRANS_DEPTH) ? TRANS_DEPTH : int'(search_limit);
    hit = -1;
    for (int k = 0; k < limit && hit < 0; k++) begin
      if (table_mirror[k].from_state == state_mirror &&
          table_mirror[k].read_symbol == under) hit = k;
    end
    if (hit < 0) begin
      halt_mirror = 1'b1;
      return res;
    end
    fired = table_mirror[hit];
    tape_mirror[head_mirror] = fired.write_symbol;
    state_mirror = fired.to_state;
    fault = 1'b0;
    if (fired.move == MOVE_RIGHT) begin
      if (head_mirror == HEAD_LAST) fault = 1'b1;
      else head_mirror = head_mirror + 1'b1;
    end else if (fired.move == MOVE_LEFT) begin
      if (head_mirror == '0) fault = 1'b1;
      else head_mirror = head_mirror - 1'b1;
    end
    if (fault) halt_mirror = 1'b1;
    res.halted     = fault;
    res.head_fault = fault;
    res.state      = state_mirror;
    res.head       = head_mirror;
    res.symbol     = fired.write_symbol;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPE_DEPTH; i++) tape_mirror[i] = '0;
      for (int i = 0; i < TRANS_DEPTH; i++) table_mirror[i] = '0;
      state_mirror = '0;
      head_mirror  = '0;
      halt_mirror  = 1'b0;
      search_limit = '0;
      step_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (step_results_q.size() == 0) begin
          $error("response with no step pending: state %0d head %0d",
                 rsp_mon.current_state, rsp_mon.head_position);
          fail_count_o++;
        end else begin
          oldest_result = step_results_q.pop_front();
          compare_field("halted", oldest_result.halted, rsp_mon.halted);
          compare_field("head_fault", oldest_result.head_fault, rsp_mon.head_fault);
          compare_field("current_state", oldest_result.state, rsp_mon.current_state);
          compare_field("head_position", oldest_result.head, rsp_mon.head_position);
          compare_field("written_symbol", oldest_result.symbol, rsp_mon.written_symbol);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) search_limit = cfg_mon.entries_in_use;
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.command)
          CMD_LOAD_TRANS: begin
            table_mirror[req_mon.entry_index].from_state   = req_mon.from_state;
            table_mirror[req_mon.entry_index].read_symbol  = req_mon.read_symbol;
            table_mirror[req_mon.entry_index].to_state     = req_mon.to_state;
            table_mirror[req_mon.entry_index].write_symbol = req_mon.write_symbol;
            table_mirror[req_mon.entry_index].move         = req_mon.move;
          end
          CMD_LOAD_TAPE: tape_mirror[req_mon.tape_address] = req_mon.tape_symbol;
          CMD_RESTART: begin
            state_mirror = '0;
            head_mirror  = '0;
            halt_mirror  = 1'b0;
          end
          CMD_STEP: step_results_q.push_back(advance_machine());
          default: ;
        endcase
      end
      pending_o = step_results_q.size();
    end
  end

endmodule

### tb/tb_turing_machine_stepper.sv
// Testbench top: drives programs, tapes and steps into the stepper and gives the verdict.
`timescale 1ns / 1ps

module tb_turing_machine_stepper;
  import tms_pkg::*;

  localparam int               STALL_LIMIT = 4000;
  localparam int               SETTLE_CYCLES = 80;
  localparam int               TOTAL_ITEMS = 550;
  localparam logic [MOVE_W-1:0] MOVE_UNDEF = 2'd3;
  localparam logic [CFG_W-1:0]  CFG_MAX = {CFG_W{1'b1}};
  localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(TRANS_DEPTH - 1);

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ENTRY_W-1:0] entry_index;
    entry_t             entry;
    logic [TAPE_AW-1:0] tape_address;
    logic [SYM_W-1:0]   tape_symbol;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm = 1'b0;
  int   sent_items = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;

  tms_req_if req_ch ();
  tms_rsp_if rsp_ch ();
  tms_cfg_if cfg_ch ();

  turing_machine_stepper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  tms_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_turing_machine_stepper failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 4) != 0) return SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic entry_t program_entry();
    entry_t e;
    e.from_state   = STATE_W'($urandom_range(0, 3));
    e.read_symbol  = pick_symbol();
    e.to_state     = STATE_W'($urandom_range(0, 3));
    e.write_symbol = pick_symbol();
    e.move         = MOVE_W'($urandom_range(0, 3));
    return e;
  endfunction

  function automatic entry_t make_entry(input logic [STATE_W-1:0] src_state,
                                        input logic [SYM_W-1:0] seen,
                                        input logic [STATE_W-1:0] dst_state,
                                        input logic [SYM_W-1:0] put,
                                        input logic [MOVE_W-1:0] mv);
    entry_t e;
    e.from_state   = src_state;
    e.read_symbol  = seen;
    e.to_state     = dst_state;
    e.write_symbol = put;
    e.move         = mv;
    return e;
  endfunction

  function automatic request_t random_request(input logic [CMD_W-1:0] cmd);
    request_t r;
    r = request_t'({$urandom, $urandom});
    r.command = cmd;
    return r;
  endfunction

  // Ready side of the response channel: random stalls unless the phase is calm.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input request_t r);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.command      <= r.command;
    req_ch.entry_index  <= r.entry_index;
    req_ch.from_state   <= r.entry.from_state;
    req_ch.read_symbol  <= r.entry.read_symbol;
    req_ch.to_state     <= r.entry.to_state;
    req_ch.write_symbol <= r.entry.write_symbol;
    req_ch.move         <= r.entry.move;
    req_ch.tape_address <= r.tape_address;
    req_ch.tape_symbol  <= r.tape_symbol;
    req_ch.valid        <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_items++;
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd);
    send_req(random_request(cmd));
  endtask

  task automatic load_entry(input logic [ENTRY_W-1:0] idx, input entry_t e);
    request_t r;
    r = random_request(CMD_LOAD_TRANS);
    r.entry_index = idx;
    r.entry = e;
    send_req(r);
  endtask

  task automatic load_cell(input logic [TAPE_AW-1:0] addr, input logic [SYM_W-1:0] sym);
    request_t r;
    r = random_request(CMD_LOAD_TAPE);
    r.tape_address = addr;
    r.tape_symbol = sym;
    send_req(r);
  endtask

  // Drop the request stream and let the block drain before touching the register.
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.entries_in_use <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int prog_len;
    int cell_loads;
    int run_len;
    int roll;
    req_ch.valid        = 1'b0;
    req_ch.command      = '0;
    req_ch.entry_index  = '0;
    req_ch.from_state   = '0;
    req_ch.read_symbol  = '0;
    req_ch.to_state     = '0;
    req_ch.write_symbol = '0;
    req_ch.move         = '0;
    req_ch.tape_address = '0;
    req_ch.tape_symbol  = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.entries_in_use = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the head across the cleared tape into the right edge
    cfg_write(CFG_W'(1));
    load_entry('0, make_entry('0, '0, '0, '0, MOVE_RIGHT));
    repeat (TAPE_DEPTH + 1) issue(CMD_STEP);

    for (int i = 0; i < TRANS_DEPTH; i++) begin
      load_entry(ENTRY_W'(i), ($urandom_range(0, 1) != 0) ? program_entry() : entry_t'($urandom));
    end

    settle();
    cfg_write('0);
    issue(CMD_RESTART);
    issue(CMD_STEP);
    issue(CMD_STEP);

    settle();
    cfg_write(CFG_MAX);
    load_cell('0, 8'hFF);
    load_cell(HEAD_LAST, 8'hA5);
    load_entry('0, make_entry('0, 8'hFF, 4'd15, 8'h00, MOVE_LEFT));
    issue(CMD_RESTART);
    issue(CMD_STEP);
    issue(CMD_STEP);
    issue(CMD_RESTART);
    load_entry('0, make_entry('0, 8'h00, 4'd3, 8'hFF, MOVE_UNDEF));
    issue(CMD_STEP);
    load_entry(ENTRY_LAST, make_entry(4'd3, 8'hFF, '0, 8'h5A, MOVE_RIGHT));
    issue(CMD_STEP);

    settle();
    cfg_write(CFG_W'(TRANS_DEPTH));
    issue(CMD_RESTART);
    issue(CMD_STEP);
    issue(CMD_STEP);

    while (sent_items < TOTAL_ITEMS) begin
      settle();
      roll = $urandom_range(0, 9);
      case (roll)
        0: cfg_write('0);
        1: cfg_write(CFG_W'(TRANS_DEPTH));
        2: cfg_write(CFG_MAX);
        3: cfg_write(CFG_W'($urandom_range(TRANS_DEPTH + 1, 127)));
        4: cfg_write(CFG_W'(1));
        default: cfg_write(CFG_W'($urandom_range(2, TRANS_DEPTH)));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      prog_len = $urandom_range(6, 16);
      for (int i = 0; i < prog_len; i++) load_entry(ENTRY_W'(i), program_entry());
      cell_loads = $urandom_range(0, 6);
      repeat (cell_loads) begin
        load_cell(($urandom_range(0, 4) == 0) ? TAPE_AW'($urandom_range(0, 255))
                                              : TAPE_AW'($urandom_range(0, 15)),
                  pick_symbol());
      end
      issue(CMD_RESTART);
      run_len = $urandom_range(8, 40);
      repeat (run_len) begin
        roll = $urandom_range(0, 19);
        case (roll)
          0: issue(CMD_LOAD_TRANS);
          1: issue(CMD_LOAD_TAPE);
          2: issue(CMD_RESTART);
          default: issue(CMD_STEP);
        endcase
      end
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_turing_machine_stepper passed");
    end else begin
      $display("tb_turing_machine_stepper failed");
    end
    $finish;
  end

endmodule
